/* hw/rtl/rldc_pkg.sv */
// ----------------------------------------------------------------------------
// rldc_pkg
// Shared types, codes and the control store of the run-length deque consumer.
// ----------------------------------------------------------------------------
package rldc_pkg;

   // Field widths
   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int UNIT_W   = 20;
   localparam int TOTAL_W  = 28;
   localparam int STATUS_W = 2;
   localparam int STEP_W   = 4;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [STEP_W-1:0]   step_type;
   typedef logic [2:0]          act_type;
   typedef logic [2:0]          cond_type;
   typedef logic [1:0]          res_sel_type;

   // Opcodes
   localparam opcode_type OP_ADD     = 2'd0;
   localparam opcode_type OP_DELETE  = 2'd1;
   localparam opcode_type OP_REVERSE = 2'd2;

   // Status codes
   localparam status_type STAT_OK    = 2'd0;
   localparam status_type STAT_FULL  = 2'd1;
   localparam status_type STAT_EMPTY = 2'd2;

   // Datapath actions
   localparam act_type ACT_NONE    = 3'd0;
   localparam act_type ACT_ADD     = 3'd1;
   localparam act_type ACT_CAPTURE = 3'd2;
   localparam act_type ACT_WALK    = 3'd3;
   localparam act_type ACT_TOGGLE  = 3'd4;

   // Result sources
   localparam res_sel_type RES_TOTAL_OK   = 2'd0;
   localparam res_sel_type RES_TOTAL_FULL = 2'd1;
   localparam res_sel_type RES_HEAD       = 2'd2;
   localparam res_sel_type RES_EMPTY      = 2'd3;

   // Jump conditions
   localparam cond_type COND_NEXT      = 3'd0;
   localparam cond_type COND_ALWAYS    = 3'd1;
   localparam cond_type COND_DISPATCH  = 3'd2;
   localparam cond_type COND_FULL      = 3'd3;
   localparam cond_type COND_EMPTY     = 3'd4;
   localparam cond_type COND_REM_ZERO  = 3'd5;
   localparam cond_type COND_WALK_DONE = 3'd6;

   // Program addresses
   localparam step_type STEP_FETCH      = 4'd0;
   localparam step_type STEP_ADD        = 4'd1;
   localparam step_type STEP_ADD_DO     = 4'd2;
   localparam step_type STEP_EMIT_TOTAL = 4'd3;
   localparam step_type STEP_EMIT_FULL  = 4'd4;
   localparam step_type STEP_DEL        = 4'd5;
   localparam step_type STEP_CAPTURE    = 4'd6;
   localparam step_type STEP_WALK       = 4'd7;
   localparam step_type STEP_WAIT       = 4'd8;
   localparam step_type STEP_EMIT_HEAD  = 4'd9;
   localparam step_type STEP_EMIT_EMPTY = 4'd10;
   localparam step_type STEP_REVERSE    = 4'd11;

   // One control word of the program
   typedef struct packed {
      act_type     act;
      logic        emit;
      res_sel_type res_sel;
      cond_type    cond;
      step_type    target;
   } uword_type;

   // Control from sequencer to datapath
   typedef struct packed {
      logic        load;
      act_type     act;
      logic        emit;
      res_sel_type res_sel;
   } dp_ctl_type;

   // Flags from datapath to sequencer
   typedef struct packed {
      logic full;
      logic empty;
      logic rem_zero;
      logic walk_done;
      logic out_busy;
   } dp_stat_type;

   function automatic uword_type uword(input act_type a, input logic e, input res_sel_type r,
                                       input cond_type c, input step_type t);
      uword_type w;
      w.act     = a;
      w.emit    = e;
      w.res_sel = r;
      w.cond    = c;
      w.target  = t;
      return w;
   endfunction

   // Control store
   function automatic uword_type ucode_rom(input step_type addr);
      uword_type w;
      case (addr)
         STEP_FETCH:      w = uword(ACT_NONE, 1'b0, RES_TOTAL_OK, COND_DISPATCH, STEP_FETCH);
         STEP_ADD:        w = uword(ACT_NONE, 1'b0, RES_TOTAL_OK, COND_FULL, STEP_EMIT_FULL);
         STEP_ADD_DO:     w = uword(ACT_ADD, 1'b0, RES_TOTAL_OK, COND_NEXT, STEP_FETCH);
         STEP_EMIT_TOTAL: w = uword(ACT_NONE, 1'b1, RES_TOTAL_OK, COND_ALWAYS, STEP_FETCH);
         STEP_EMIT_FULL:  w = uword(ACT_NONE, 1'b1, RES_TOTAL_FULL, COND_ALWAYS, STEP_FETCH);
         STEP_DEL:        w = uword(ACT_NONE, 1'b0, RES_TOTAL_OK, COND_EMPTY, STEP_EMIT_EMPTY);
         STEP_CAPTURE:    w = uword(ACT_CAPTURE, 1'b0, RES_TOTAL_OK, COND_REM_ZERO,
                                    STEP_EMIT_HEAD);
         STEP_WALK:       w = uword(ACT_WALK, 1'b0, RES_TOTAL_OK, COND_WALK_DONE,
                                    STEP_EMIT_HEAD);
         STEP_WAIT:       w = uword(ACT_NONE, 1'b0, RES_TOTAL_OK, COND_ALWAYS, STEP_WALK);
         STEP_EMIT_HEAD:  w = uword(ACT_NONE, 1'b1, RES_HEAD, COND_ALWAYS, STEP_FETCH);
         STEP_EMIT_EMPTY: w = uword(ACT_NONE, 1'b1, RES_EMPTY, COND_ALWAYS, STEP_FETCH);
         STEP_REVERSE:    w = uword(ACT_TOGGLE, 1'b0, RES_TOTAL_OK, COND_ALWAYS, STEP_FETCH);
         default:         w = uword(ACT_NONE, 1'b0, RES_TOTAL_OK, COND_ALWAYS, STEP_FETCH);
      endcase
      return w;
   endfunction

   // Entry point of each opcode's routine
   function automatic step_type dispatch_target(input opcode_type op);
      step_type t;
      case (op)
         OP_ADD:     t = STEP_ADD;
         OP_DELETE:  t = STEP_DEL;
         OP_REVERSE: t = STEP_REVERSE;
         default:    t = STEP_FETCH;
      endcase
      return t;
   endfunction

endpackage

/* hw/rtl/rldc_if.sv */
// ----------------------------------------------------------------------------
// rldc_req_if / rldc_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface rldc_req_if import rldc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic signed [VALUE_W-1:0] item_value;
   logic [UNIT_W-1:0]         unit_count;

   modport source (output valid, output opcode, output item_value, output unit_count,
                   input ready);
   modport sink   (input valid, input opcode, input item_value, input unit_count,
                   output ready);
endinterface

interface rldc_rsp_if import rldc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] result_word;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, output result_word, output status, input ready);
   modport sink   (input valid, input result_word, input status, output ready);
endinterface

/* hw/rtl/rldc_seq.sv */
// ----------------------------------------------------------------------------
// rldc_seq
// Step counter and control store: fetches a control word per cycle and picks
// the next step from the jump condition.
// ----------------------------------------------------------------------------
module rldc_seq import rldc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  opcode_type  req_opcode,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_ctl_type  ctl
);

   logic      at_fetch;
   step_type  step_ff;
   step_type  step_in;
   step_type  step_inc;
   uword_type uw;
   logic      accept;
   logic      stall;

   // Current control word
   assign uw       = ucode_rom(step_ff);
   assign step_inc = step_ff + 1'b1;
   assign at_fetch = (step_ff == STEP_FETCH);
   assign req_ready = at_fetch;
   assign accept   = at_fetch & req_valid;

   // Hold an emit step while the output word is still waiting
   assign stall = uw.emit & stat.out_busy;

   // Next step
   always_comb begin
      case (uw.cond)
         COND_NEXT:      step_in = step_inc;
         COND_ALWAYS:    step_in = uw.target;
         COND_DISPATCH:  step_in = accept ? dispatch_target(req_opcode) : step_ff;
         COND_FULL:      step_in = stat.full ? uw.target : step_inc;
         COND_EMPTY:     step_in = stat.empty ? uw.target : step_inc;
         COND_REM_ZERO:  step_in = stat.rem_zero ? uw.target : step_inc;
         COND_WALK_DONE: step_in = stat.walk_done ? uw.target : step_inc;
         default:        step_in = STEP_FETCH;
      endcase
      if (stall) begin
         step_in = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

   // Datapath control
   always_comb begin
      ctl.load    = accept;
      ctl.act     = uw.act;
      ctl.emit    = uw.emit & ~stall;
      ctl.res_sel = uw.res_sel;
   end

   // Checks
   a_stall_only_emit: assert property (@(posedge clock) disable iff (reset)
      stall |=> step_ff == $past(step_ff))
      else $error("sequencer left a stalled emit step");
   a_fetch_on_accept: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_ADD) |=> step_ff == STEP_ADD)
      else $error("add not dispatched");
   a_walk_from_valid: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_WALK |-> ($past(step_ff) == STEP_CAPTURE || $past(step_ff) == STEP_WAIT))
      else $error("walk entered without a settled head read");

endmodule

/* hw/rtl/rldc_datapath.sv */
// ----------------------------------------------------------------------------
// rldc_datapath
// Run store, pointers, unit total and output register, driven by the control
// word of the sequencer.
// ----------------------------------------------------------------------------
module rldc_datapath import rldc_pkg::*; #(
   parameter int QUEUE_DEPTH = 256,
   parameter int COUNT_BITS  = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_ctl_type                ctl,
   output dp_stat_type               stat,
   input  logic signed [VALUE_W-1:0] req_item_value,
   input  logic [UNIT_W-1:0]         req_unit_count,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_result_word,
   output status_type                rsp_status
);

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W   = OCC_W + 1;
   localparam int EXT_W   = (COUNT_BITS > UNIT_W) ? COUNT_BITS : UNIT_W;
   localparam int ENTRY_W = VALUE_W + COUNT_BITS;

   // Run store: value in the upper bits, count in the lower bits
   logic [ENTRY_W-1:0] run_mem [QUEUE_DEPTH];

   logic [IDX_W-1:0]          front_ff, front_in;
   logic [OCC_W-1:0]          occ_ff, occ_in;
   logic                      rev_ff, rev_in;
   logic [TOTAL_W-1:0]        total_ff, total_in;
   logic [UNIT_W-1:0]         rem_ff, rem_in;
   logic [VALUE_W-1:0]        val_ff;
   logic [COUNT_BITS-1:0]     cnt_ff;
   logic [VALUE_W-1:0]        head_val_ff, head_val_in;
   logic [ENTRY_W-1:0]        rd_entry_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]        rsp_word_ff, rsp_word_in;
   status_type                rsp_status_ff, rsp_status_in;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [ENTRY_W-1:0]        wr_data;

   logic [IDX_W-1:0]          tail_idx, head_idx, front_dec, front_inc;
   logic [OCC_W-1:0]          occ_m1;
   logic [VALUE_W-1:0]        rd_val;
   logic [COUNT_BITS-1:0]     rd_cnt, cnt_left;
   logic [EXT_W-1:0]          cnt_in_ext, cnt_max_ext, cnt_sat_ext;
   logic [EXT_W-1:0]          rem_ext, head_cnt_ext, take_ext, rem_left_ext;
   logic [UNIT_W-1:0]         rem_next;
   logic                      run_gone;

   // Fold a sum below twice the depth back into the ring
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] w;
      w = (s >= SUM_W'(QUEUE_DEPTH)) ? s - SUM_W'(QUEUE_DEPTH) : s;
      return w[IDX_W-1:0];
   endfunction

   // Ring addresses
   assign tail_idx  = wrap_idx(SUM_W'(front_ff) + SUM_W'(occ_ff));
   assign occ_m1    = (occ_ff == '0) ? '0 : occ_ff - 1'b1;
   assign head_idx  = rev_ff ? wrap_idx(SUM_W'(front_ff) + SUM_W'(occ_m1)) : front_ff;
   assign front_dec = (front_ff == '0) ? IDX_W'(QUEUE_DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = wrap_idx(SUM_W'(front_ff) + SUM_W'(1));

   // Saturate an incoming count to the stored width
   assign cnt_in_ext  = EXT_W'(req_unit_count);
   assign cnt_max_ext = EXT_W'({COUNT_BITS{1'b1}});
   assign cnt_sat_ext = (cnt_in_ext > cnt_max_ext) ? cnt_max_ext : cnt_in_ext;

   // One walk step on the head run
   assign rd_val       = rd_entry_ff[ENTRY_W-1 -: VALUE_W];
   assign rd_cnt       = rd_entry_ff[COUNT_BITS-1:0];
   assign rem_ext      = EXT_W'(rem_ff);
   assign head_cnt_ext = EXT_W'(rd_cnt);
   assign take_ext     = (rem_ext < head_cnt_ext) ? rem_ext : head_cnt_ext;
   assign rem_left_ext = rem_ext - take_ext;
   assign rem_next     = rem_left_ext[UNIT_W-1:0];
   assign run_gone     = (head_cnt_ext == take_ext);
   assign cnt_left     = rd_cnt - take_ext[COUNT_BITS-1:0];

   // State updates
   always_comb begin
      front_in    = front_ff;
      occ_in      = occ_ff;
      rev_in      = rev_ff;
      total_in    = total_ff;
      rem_in      = rem_ff;
      head_val_in = head_val_ff;
      wr_en       = 1'b0;
      wr_addr     = head_idx;
      wr_data     = {rd_val, cnt_left};
      case (ctl.act)
         ACT_ADD: begin
            wr_en    = 1'b1;
            wr_data  = {val_ff, cnt_ff};
            occ_in   = occ_ff + 1'b1;
            total_in = total_ff + TOTAL_W'(cnt_ff);
            if (rev_ff) begin
               front_in = front_dec;
               wr_addr  = front_dec;
            end else begin
               wr_addr  = tail_idx;
            end
         end
         ACT_CAPTURE: begin
            head_val_in = rd_val;
         end
         ACT_WALK: begin
            rem_in   = rem_next;
            total_in = total_ff - TOTAL_W'(take_ext);
            if (run_gone) begin
               occ_in = occ_ff - 1'b1;
               if (!rev_ff) begin
                  front_in = front_inc;
               end
            end else begin
               wr_en = 1'b1;
            end
         end
         ACT_TOGGLE: begin
            rev_in = ~rev_ff;
         end
         default: begin
         end
      endcase
      if (ctl.load) begin
         rem_in = req_unit_count;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         case (ctl.res_sel)
            RES_TOTAL_OK: begin
               rsp_word_in   = VALUE_W'(total_ff);
               rsp_status_in = STAT_OK;
            end
            RES_TOTAL_FULL: begin
               rsp_word_in   = VALUE_W'(total_ff);
               rsp_status_in = STAT_FULL;
            end
            RES_HEAD: begin
               rsp_word_in   = head_val_ff;
               rsp_status_in = STAT_OK;
            end
            default: begin
               rsp_word_in   = '0;
               rsp_status_in = STAT_EMPTY;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         occ_ff       <= '0;
         rev_ff       <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rev_ff       <= rev_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      head_val_ff   <= head_val_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      if (ctl.load) begin
         val_ff <= req_item_value;
         cnt_ff <= cnt_sat_ext[COUNT_BITS-1:0];
      end
   end

   // Run store: one write port, one registered read at the head
   always_ff @(posedge clock) begin
      if (wr_en) begin
         run_mem[wr_addr] <= wr_data;
      end
      rd_entry_ff <= run_mem[head_idx];
   end

   // Flags
   always_comb begin
      stat.full      = (occ_ff == OCC_W'(QUEUE_DEPTH));
      stat.empty     = (occ_ff == '0);
      stat.rem_zero  = (rem_ff == '0);
      stat.walk_done = (rem_next == '0) || (run_gone && occ_ff == OCC_W'(1));
      stat.out_busy  = rsp_valid_ff & ~rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_word = rsp_word_ff;
   assign rsp_status      = rsp_status_ff;

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("occupancy above depth");
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      ctl.act == ACT_ADD |=> occ_ff == OCC_W'($past(occ_ff) + 1'b1))
      else $error("add did not grow the queue");
   a_walk_has_run: assert property (@(posedge clock) disable iff (reset)
      ctl.act == ACT_WALK |-> occ_ff != '0)
      else $error("walk on an empty queue");
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |=> rsp_valid_ff)
      else $error("emitted word not presented");

endmodule

/* hw/rtl/run_length_deque_consumer.sv */
// ----------------------------------------------------------------------------
// run_length_deque_consumer
// Deque of value/count runs with a unit total and a direction flag.
// ----------------------------------------------------------------------------
// From accept to response: add checks for room, writes the run, then loads the
// total; a refused add or a delete on empty loads its response at once; a delete
// captures the head value, then walks with a store read and an update per run.
// Reverse gives no response. A new word is taken after the response is loaded;
// a response step waits while the previous response is still held. Reset is
// synchronous: queue empty, total zero, direction forward; store not cleared.
module run_length_deque_consumer import rldc_pkg::*; #(
   parameter int QUEUE_DEPTH = 256,
   parameter int COUNT_BITS  = 20
) (
   input logic        clock,
   input logic        reset,
   rldc_req_if.sink   req_chan,
   rldc_rsp_if.source rsp_chan
);

   dp_ctl_type  ctl;
   dp_stat_type stat;
   logic        req_ready;

   // Sequencer
   rldc_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_ready),
      .stat       (stat),
      .ctl        (ctl)
   );

   assign req_chan.ready = req_ready;

   // Datapath
   rldc_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .COUNT_BITS  (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_item_value  (req_chan.item_value),
      .req_unit_count  (req_chan.unit_count),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_result_word (rsp_chan.result_word),
      .rsp_status      (rsp_chan.status)
   );

endmodule

/* tb/run_length_deque_consumer_test.sv */
// ----------------------------------------------------------------------------
// run_length_deque_consumer_test
// Self-checking bench for the run-length deque. Every accepted request word
// also runs through a behavioral copy of the deque kept in the bench. That
// copy holds the runs, the unit total and the direction flag, and it queues
// the response word it expects. A checker compares each response field by
// field. Request and response sides idle at random, and one test holds the
// response side off for a long stretch.
// ----------------------------------------------------------------------------
module run_length_deque_consumer_test;
   import rldc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int         QUEUE_SLOTS  = 256;
   localparam int         RSP_SLOTS    = 16;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         WATCHDOG_MAX = 5000;
   localparam opcode_type OP_UNUSED    = 2'd3;
   localparam logic [UNIT_W-1:0] UNIT_MAX = {UNIT_W{1'b1}};

   typedef struct {
      logic signed [VALUE_W-1:0] word;
      status_type                status;
   } rsp_word_type;

   logic clock;
   logic reset;

   rldc_req_if req_bus ();
   rldc_rsp_if rsp_bus ();

   run_length_deque_consumer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Bench copy of the deque
   logic [VALUE_W-1:0] run_val_mem [QUEUE_SLOTS];
   logic [UNIT_W-1:0]  run_cnt_mem [QUEUE_SLOTS];
   int                 first_slot;
   int                 runs_held;
   logic               flipped;
   logic [TOTAL_W-1:0] units_held;

   // Awaited responses: written by the sender side, read by the checker
   rsp_word_type awaited_rsp [RSP_SLOTS];
   int           rsp_wr_count;
   int           rsp_rd_count = 0;

   // Run control shared between processes
   bit no_idle;
   int hold_asks;
   int idle_cycles = 0;

   // Tallies
   int errors = 0;
   int words_sent;
   int rsp_checked = 0;
   int refused_adds;
   int empty_deletes;
   int deepest;

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Logical head of the deque: physical front, or back when reversed
   function automatic int head_slot();
      if (!flipped) begin
         return first_slot;
      end
      return (first_slot + runs_held - 1) % QUEUE_SLOTS;
   endfunction

   // Record one awaited response word
   function automatic void log_awaited(input rsp_word_type w);
      awaited_rsp[rsp_wr_count % RSP_SLOTS] = w;
      rsp_wr_count++;
   endfunction

   // Advance the bench deque by one accepted word, queue any response
   task automatic apply_word(input opcode_type op, input logic [VALUE_W-1:0] val,
                             input logic [UNIT_W-1:0] cnt);
      rsp_word_type exp;
      logic [UNIT_W-1:0] remaining;
      logic [UNIT_W-1:0] take;
      int slot;
      case (op)
         OP_ADD: begin
            if (runs_held >= QUEUE_SLOTS) begin
               exp.word   = {{(VALUE_W-TOTAL_W){1'b0}}, units_held};
               exp.status = STAT_FULL;
               refused_adds++;
            end else begin
               if (!flipped) begin
                  slot = (first_slot + runs_held) % QUEUE_SLOTS;
               end else begin
                  first_slot = (first_slot == 0) ? QUEUE_SLOTS - 1 : first_slot - 1;
                  slot = first_slot;
               end
               run_val_mem[slot] = val;
               run_cnt_mem[slot] = cnt;
               runs_held++;
               units_held = units_held + TOTAL_W'(cnt);
               if (runs_held > deepest) begin
                  deepest = runs_held;
               end
               exp.word   = {{(VALUE_W-TOTAL_W){1'b0}}, units_held};
               exp.status = STAT_OK;
            end
            log_awaited(exp);
         end
         OP_DELETE: begin
            if (runs_held == 0) begin
               exp.word   = '0;
               exp.status = STAT_EMPTY;
               empty_deletes++;
            end else begin
               exp.word   = run_val_mem[head_slot()];
               exp.status = STAT_OK;
               remaining  = cnt;
               // consume run by run from the logical head
               while (runs_held != 0 && remaining != 0) begin
                  slot = head_slot();
                  take = (remaining < run_cnt_mem[slot]) ? remaining : run_cnt_mem[slot];
                  remaining  = remaining - take;
                  units_held = units_held - TOTAL_W'(take);
                  if (run_cnt_mem[slot] == take) begin
                     if (!flipped) begin
                        first_slot = (first_slot + 1) % QUEUE_SLOTS;
                     end
                     runs_held--;
                  end else begin
                     run_cnt_mem[slot] = run_cnt_mem[slot] - take;
                  end
               end
            end
            log_awaited(exp);
         end
         OP_REVERSE: begin
            flipped = !flipped;
         end
         default: ;
      endcase
   endtask

   // Offer one word, wait for it to be taken; valid stays high afterward
   task automatic send_word(input opcode_type op, input logic [VALUE_W-1:0] val,
                            input logic [UNIT_W-1:0] cnt);
      if (!no_idle) begin
         while ($urandom_range(99) < 25) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.item_value <= val;
      req_bus.unit_count <= cnt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      apply_word(op, val, cnt);
      words_sent++;
   endtask

   // Drop valid and wait until every awaited response has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (rsp_wr_count != rsp_rd_count) @(posedge clock);
   endtask

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_wr_count == rsp_rd_count) begin
            $display("%0t: unexpected response word %h status %0d", $time,
                     rsp_bus.result_word, rsp_bus.status);
            errors++;
         end else begin
            if (rsp_bus.result_word !== awaited_rsp[rsp_rd_count % RSP_SLOTS].word) begin
               $display("%0t: result_word expected %h actual %h", $time,
                        awaited_rsp[rsp_rd_count % RSP_SLOTS].word, rsp_bus.result_word);
               errors++;
            end
            if (rsp_bus.status !== awaited_rsp[rsp_rd_count % RSP_SLOTS].status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        awaited_rsp[rsp_rd_count % RSP_SLOTS].status, rsp_bus.status);
               errors++;
            end
            rsp_rd_count++;
            rsp_checked++;
         end
      end
   end

   // Ready pattern, with a counted hold-off whenever a test asks for one
   initial begin
      int hold_left;
      int asks_seen;
      hold_left = 0;
      asks_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != asks_seen) begin
            asks_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 25);
         end
      end
   end

   // Watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_MAX);
         $display("run_length_deque_consumer_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Random count, mostly small, sometimes zero or full range
   function automatic logic [UNIT_W-1:0] pick_count(input int span);
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) begin
         return '0;
      end else if (roll < 85) begin
         return UNIT_W'($urandom_range(span, 1));
      end
      return UNIT_W'($urandom);
   endfunction

   // Field extremes, zero counts, empty deletes, reverse and the unused opcode
   task automatic test_corner_words();
      send_word(OP_DELETE, 32'd0, 20'd5);
      send_word(OP_ADD, 32'h7fffffff, UNIT_MAX);
      send_word(OP_ADD, 32'h80000000, 20'd0);
      send_word(OP_ADD, 32'd0, 20'd1);
      send_word(OP_DELETE, 32'hffffffff, 20'd0);
      send_word(OP_DELETE, 32'd0, UNIT_MAX);
      send_word(OP_DELETE, 32'd0, 20'd1);
      send_word(OP_DELETE, 32'd0, 20'd1);
      send_word(OP_ADD, 32'd5, 20'd3);
      send_word(OP_ADD, -32'sd7, 20'd2);
      send_word(OP_REVERSE, 32'd0, 20'd0);
      send_word(OP_DELETE, 32'd0, 20'd1);
      send_word(OP_ADD, 32'd9, 20'd4);
      send_word(OP_DELETE, 32'd0, UNIT_MAX);
      send_word(OP_DELETE, 32'd0, 20'd0);
      send_word(OP_UNUSED, 32'hffffffff, UNIT_MAX);
      send_word(OP_REVERSE, 32'hffffffff, UNIT_MAX);
      send_word(OP_ADD, 32'd1, 20'd1);
      send_word(OP_DELETE, 32'd0, 20'd0);
      drain();
   endtask

   // Fill to capacity with no idling, hit refusals, then empty in one walk
   task automatic test_fill_and_refuse();
      no_idle = 1'b1;
      while (runs_held < QUEUE_SLOTS) begin
         send_word(OP_ADD, $urandom, UNIT_W'($urandom_range(8, 1)));
      end
      send_word(OP_ADD, $urandom, UNIT_MAX);
      send_word(OP_ADD, $urandom, 20'd1);
      send_word(OP_REVERSE, 32'd0, 20'd0);
      send_word(OP_ADD, $urandom, 20'd3);
      send_word(OP_DELETE, 32'd0, 20'd5);
      send_word(OP_ADD, $urandom, 20'd2);
      send_word(OP_DELETE, 32'd0, UNIT_MAX);
      send_word(OP_DELETE, 32'd0, 20'd1);
      drain();
      no_idle = 1'b0;
   endtask

   // Response side held off while requests keep coming
   task automatic test_output_stall();
      hold_asks++;
      for (int i = 0; i < 40; i++) begin
         if (i % 5 == 4) begin
            send_word(OP_DELETE, 32'd0, pick_count(6));
         end else begin
            send_word(OP_ADD, $urandom, pick_count(12));
         end
      end
      drain();
   endtask

   // Random mix steered by queue depth, with occasional pauses to drain
   task automatic test_random_mix(input int count);
      int roll;
      int add_odds;
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         add_odds = (runs_held < 4) ? 70 : (runs_held > 200) ? 30 : 48;
         if (roll < 8) begin
            send_word(OP_REVERSE, $urandom, UNIT_W'($urandom));
         end else if (roll < 11) begin
            send_word(OP_UNUSED, $urandom, UNIT_W'($urandom));
         end else if (roll < 11 + add_odds) begin
            send_word(OP_ADD, $urandom, pick_count(16));
         end else begin
            send_word(OP_DELETE, $urandom, pick_count(24));
         end
         if ($urandom_range(199) == 0) begin
            drain();
         end
      end
      drain();
   endtask

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_ADD;
      req_bus.item_value <= '0;
      req_bus.unit_count <= '0;
      first_slot = 0;
      runs_held  = 0;
      flipped    = 1'b0;
      units_held = '0;
      rsp_wr_count = 0;
      no_idle    = 1'b0;
      hold_asks  = 0;
      words_sent = 0;
      refused_adds = 0;
      empty_deletes = 0;
      deepest = 0;
      @(posedge clock);
      while (reset) @(posedge clock);

      test_corner_words();
      test_fill_and_refuse();
      test_output_stall();
      test_random_mix(1300);

      repeat (20) @(posedge clock);
      $display("Sent %0d request words, checked %0d responses.", words_sent, rsp_checked);
      $display("Refused adds %0d, empty deletes %0d, deepest queue %0d runs.",
               refused_adds, empty_deletes, deepest);
      if (errors == 0 && rsp_wr_count == rsp_rd_count) begin
         $display("run_length_deque_consumer_test passed");
      end else begin
         $display("run_length_deque_consumer_test failed");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/rldc_pkg.sv
hw/rtl/rldc_if.sv
hw/rtl/rldc_seq.sv
hw/rtl/rldc_datapath.sv
hw/rtl/run_length_deque_consumer.sv
tb/run_length_deque_consumer_test.sv
